// ----- rtl/core/clsw_pkg.sv -----
// Package: command codes, microcode word layout and control store for the LCD writer.
`timescale 1ns / 1ps
package clsw_pkg;

	// Host command codes
	typedef enum logic [1:0] {
		CMD_INIT   = 2'd0,
		CMD_CLEAR  = 2'd1,
		CMD_CURSOR = 2'd2,
		CMD_WRITE  = 2'd3
	} cmd_t;

	// Nibble source for a pulse step
	typedef enum logic [1:0] {
		SRC_CONST = 2'd0,
		SRC_HI    = 2'd1,
		SRC_LO    = 2'd2
	} src_t;

	// One control word
	typedef struct packed {
		logic       emit;    // step produces a pulse
		src_t       src;
		logic [3:0] nib;     // constant nibble
		logic [5:0] pre;     // pause ahead of the pulse
		logic [2:0] after;
		logic       fin;     // last step of the run
		logic       decide;  // write-char compare step
	} uword_t;

	localparam int PC_W = 5;
	typedef logic [PC_W-1:0] pc_t;

	// Entry points into the control store
	localparam pc_t PC_INIT   = 5'd0;
	localparam pc_t PC_CLEAR  = 5'd12;
	localparam pc_t PC_BYTE   = 5'd14;
	localparam pc_t PC_DECIDE = 5'd16;

	localparam logic [7:0] BASE_ROW0 = 8'h80;
	localparam logic [7:0] BASE_ROW1 = 8'hC0;
	localparam logic [7:0] SPACE     = 8'h20;

	// Control store
	function automatic uword_t ucode(input pc_t pc);
		uword_t w;
		w = '{emit: 1'b1, src: SRC_CONST, nib: 4'h0, pre: 6'd0, after: 3'd0,
			fin: 1'b0, decide: 1'b0};
		case (pc)
			// init: reset nibbles
			5'd0:  begin w.nib = 4'h3; w.pre = 6'd50; w.after = 3'd5; end
			5'd1:  begin w.nib = 4'h3; w.after = 3'd1; end
			5'd2:  begin w.nib = 4'h3; w.after = 3'd1; end
			5'd3:  begin w.nib = 4'h2; w.after = 3'd1; end
			// init: setup bytes 0x28, 0x0C, 0x01, 0x06
			5'd4:  w.nib = 4'h2;
			5'd5:  begin w.nib = 4'h8; w.after = 3'd1; end
			5'd6:  w.nib = 4'h0;
			5'd7:  begin w.nib = 4'hC; w.after = 3'd1; end
			5'd8:  w.nib = 4'h0;
			5'd9:  begin w.nib = 4'h1; w.after = 3'd2; end
			5'd10: w.nib = 4'h0;
			5'd11: begin w.nib = 4'h6; w.after = 3'd1; w.fin = 1'b1; end
			// clear display byte
			5'd12: w.nib = 4'h0;
			5'd13: begin w.nib = 4'h1; w.after = 3'd2; w.fin = 1'b1; end
			// byte from the byte register
			5'd14: w.src = SRC_HI;
			5'd15: begin w.src = SRC_LO; w.after = 3'd1; w.fin = 1'b1; end
			// write char: compare with shadow, pick the byte
			5'd16: begin w.emit = 1'b0; w.decide = 1'b1; end
			default: begin w.emit = 1'b0; w.fin = 1'b1; end
		endcase
		return w;
	endfunction

	// DDRAM address command for a cell
	function automatic logic [7:0] ddram_addr(input logic [1:0] r, input logic [5:0] c);
		return ((r == 2'd0) ? BASE_ROW0 : BASE_ROW1) + {2'b00, c};
	endfunction

endpackage

// ----- rtl/core/char_lcd_shadow_writer.sv -----
// Top level: microcoded command sequencer for a 4-bit character LCD with shadow copy.
//
// Usage: raise start with command/row/column/character while busy is low; the
// command is taken at that edge and busy rises until its run is issued.
// Each pulse appears on reg_select/nibble/wait_before_ms/wait_after_ms/last
// for one cycle with strobe high; last marks the final pulse of the run.
// The receiver cannot stall: pulses go out one per cycle as the control
// store steps.
// Order: write char first passes a compare step against the shadow cell read
// at acceptance; init, clear and set cursor start with pulse steps.
// An init issues 12 pulses, clear and set cursor 2, write char 0 or 2; the
// steps through the control store set these figures.
// A write char that sends nothing drops busy at its compare step.
// Reset: asynchronous, clears the cursor and marks every shadow cell as
// unwritten, so it reads as zero until init or clear blanks it to spaces.
`timescale 1ns / 1ps
module char_lcd_shadow_writer #(
	parameter int COLUMNS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] command,
	input  logic [1:0] row,
	input  logic [5:0] column,
	input  logic [7:0] character,
	output logic       strobe,
	output logic       reg_select,
	output logic [3:0] nibble,
	output logic [5:0] wait_before_ms,
	output logic [2:0] wait_after_ms,
	output logic       last
);
	import clsw_pkg::*;

	localparam int DEPTH = 2 * COLUMNS;
	localparam int IW    = $clog2(DEPTH);
	localparam logic [6:0] COLS7 = 7'(COLUMNS);

	// Sequencer and datapath registers
	logic             busy_q;
	pc_t              pc_q;
	logic [1:0]       crow_q;
	logic [5:0]       ccol_q;
	logic [7:0]       byte_q;
	logic             rs_q;
	logic [7:0]       char_q;
	logic             inrange_q;
	logic [IW-1:0]    idx_q;
	logic             blank_q;
	logic [DEPTH-1:0] written_q;
	logic [7:0]       rd_q;
	logic [7:0]       mem [DEPTH];

	logic             strobe_q, rs_out_q, last_q;
	logic [3:0]       nib_q;
	logic [5:0]       before_q;
	logic [2:0]       after_q;

	logic             accept;
	uword_t           uw;
	logic             inrange;
	logic [6:0]       idx_full;
	logic [IW-1:0]    idx;
	logic [7:0]       shadow_rd;
	logic             differs;
	logic [5:0]       col_inc;
	logic             col_inc_ok;
	logic             mem_we;
	logic [3:0]       nib_sel;

	assign accept = start && !busy_q;
	assign uw     = ucode(pc_q);

	// Shadow index of the current cursor
	assign inrange  = (crow_q[1] == 1'b0) && ({1'b0, ccol_q} < COLS7);
	assign idx_full = crow_q[0] ? (COLS7 + {1'b0, ccol_q}) : {1'b0, ccol_q};
	assign idx      = idx_full[IW-1:0];

	// Shadow cell value as seen by the compare step
	assign shadow_rd  = written_q[idx_q] ? rd_q : (blank_q ? SPACE : 8'h00);
	assign differs    = (shadow_rd != char_q);
	assign col_inc    = ccol_q + 6'd1;
	assign col_inc_ok = ({1'b0, col_inc} < COLS7);
	assign mem_we     = busy_q && uw.decide && inrange_q && differs;

	// Nibble selection for the pulse
	always_comb begin
		case (uw.src)
			SRC_HI:  nib_sel = byte_q[7:4];
			SRC_LO:  nib_sel = byte_q[3:0];
			default: nib_sel = uw.nib;
		endcase
	end

	// Shadow memory: read on acceptance, write on compare
	always_ff @(posedge clk) begin
		if (accept && inrange)
			rd_q <= mem[idx];
		if (mem_we)
			mem[idx_q] <= char_q;
	end

	// Control and cursor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			pc_q      <= PC_INIT;
			crow_q    <= 2'd0;
			ccol_q    <= 6'd0;
			blank_q   <= 1'b0;
			written_q <= '0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= busy_q && uw.emit;
			if (accept) begin
				busy_q <= 1'b1;
				case (cmd_t'(command))
					CMD_INIT: begin
						pc_q      <= PC_INIT;
						crow_q    <= 2'd0;
						ccol_q    <= 6'd0;
						blank_q   <= 1'b1;
						written_q <= '0;
					end
					CMD_CLEAR: begin
						pc_q      <= PC_CLEAR;
						crow_q    <= 2'd0;
						ccol_q    <= 6'd0;
						blank_q   <= 1'b1;
						written_q <= '0;
					end
					CMD_CURSOR: begin
						pc_q   <= PC_BYTE;
						crow_q <= row;
						ccol_q <= column;
					end
					default: pc_q <= PC_DECIDE;
				endcase
			end else if (busy_q) begin
				if (uw.decide) begin
					if (!inrange_q) begin
						busy_q <= 1'b0;
					end else begin
						ccol_q <= col_inc;
						if (differs) begin
							written_q[idx_q] <= 1'b1;
							pc_q             <= PC_BYTE;
						end else if (col_inc_ok) begin
							pc_q <= PC_BYTE;
						end else begin
							busy_q <= 1'b0;
						end
					end
				end else if (uw.fin) begin
					busy_q <= 1'b0;
				end else begin
					pc_q <= pc_q + 5'd1;
				end
			end
		end
	end

	// Datapath registers: item capture and byte to send
	always_ff @(posedge clk) begin
		if (accept) begin
			char_q    <= character;
			inrange_q <= inrange;
			idx_q     <= idx;
			rs_q      <= 1'b0;
			byte_q    <= ddram_addr(row, column);
		end else if (busy_q && uw.decide) begin
			if (differs) begin
				byte_q <= char_q;
				rs_q   <= 1'b1;
			end else begin
				byte_q <= ddram_addr(crow_q, col_inc);
				rs_q   <= 1'b0;
			end
		end
	end

	// Pulse output register
	always_ff @(posedge clk) begin
		if (busy_q && uw.emit) begin
			rs_out_q <= (uw.src == SRC_CONST) ? 1'b0 : rs_q;
			nib_q    <= nib_sel;
			before_q <= uw.pre;
			after_q  <= uw.after;
			last_q   <= uw.fin;
		end
	end

	assign busy           = busy_q;
	assign strobe         = strobe_q;
	assign reg_select     = rs_out_q;
	assign nibble         = nib_q;
	assign wait_before_ms = before_q;
	assign wait_after_ms  = after_q;
	assign last           = last_q;

endmodule

// ----- test/char_lcd_shadow_writer_checker.sv -----
// Checker: predicts the LCD pulse runs from each accepted command and compares every strobe.
`timescale 1ns / 1ps
module char_lcd_shadow_writer_checker #(
	parameter int COLUMNS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic [1:0] command,
	input  logic [1:0] row,
	input  logic [5:0] column,
	input  logic [7:0] character,
	input  logic       strobe,
	input  logic       reg_select,
	input  logic [3:0] nibble,
	input  logic [5:0] wait_before_ms,
	input  logic [2:0] wait_after_ms,
	input  logic       last,
	output int         fails,
	output int         pending,
	output int         checked
);
	import clsw_pkg::*;

	typedef struct packed {
		logic       rs;
		logic [3:0] nib;
		logic [5:0] pre;
		logic [2:0] after;
		logic       fin;
	} lcd_pulse_t;

	lcd_pulse_t expected_pulses[$];
	logic [7:0] shadow[0:2*COLUMNS-1];
	logic [1:0] cur_row;
	logic [5:0] cur_col;

	initial begin
		fails   = 0;
		pending = 0;
		checked = 0;
	end

	// queue one enable pulse
	task automatic push_nibble(input logic rs, input logic [3:0] nib, input logic [5:0] pre,
			input logic [2:0] after, input logic fin);
		lcd_pulse_t p;
		p.rs    = rs;
		p.nib   = nib;
		p.pre   = pre;
		p.after = after;
		p.fin   = fin;
		expected_pulses.push_back(p);
	endtask

	// a byte: high nibble with no pause, low nibble carries the pause
	task automatic push_byte(input logic rs, input logic [7:0] b, input logic [2:0] after,
			input logic fin);
		push_nibble(rs, b[7:4], 6'd0, 3'd0, 1'b0);
		push_nibble(rs, b[3:0], 6'd0, after, fin);
	endtask

	function automatic logic [7:0] cell_address(input logic [1:0] r, input logic [5:0] c);
		logic [7:0] base;
		base = (r == 2'd0) ? 8'h80 : 8'hC0;
		return base + {2'b00, c};
	endfunction

	task automatic blank_display();
		for (int i = 0; i < 2 * COLUMNS; i++)
			shadow[i] = 8'h20;
		cur_row = 2'd0;
		cur_col = 6'd0;
	endtask

	// work out the pulse run for one command and update the shadow copy
	task automatic predict_pulses(input cmd_t c, input logic [1:0] r, input logic [5:0] col,
			input logic [7:0] ch);
		int idx;
		case (c)
			CMD_INIT: begin
				blank_display();
				push_nibble(1'b0, 4'h3, 6'd50, 3'd5, 1'b0);
				push_nibble(1'b0, 4'h3, 6'd0, 3'd1, 1'b0);
				push_nibble(1'b0, 4'h3, 6'd0, 3'd1, 1'b0);
				push_nibble(1'b0, 4'h2, 6'd0, 3'd1, 1'b0);
				push_byte(1'b0, 8'h28, 3'd1, 1'b0);
				push_byte(1'b0, 8'h0C, 3'd1, 1'b0);
				push_byte(1'b0, 8'h01, 3'd2, 1'b0);
				push_byte(1'b0, 8'h06, 3'd1, 1'b1);
			end
			CMD_CLEAR: begin
				push_byte(1'b0, 8'h01, 3'd2, 1'b1);
				blank_display();
			end
			CMD_CURSOR: begin
				push_byte(1'b0, cell_address(r, col), 3'd1, 1'b1);
				cur_row = r;
				cur_col = col;
			end
			default: begin
				// cursor off the display: nothing happens
				if (cur_row < 2'd2 && cur_col < COLUMNS) begin
					idx = int'(cur_row) * COLUMNS + int'(cur_col);
					if (shadow[idx] != ch) begin
						shadow[idx] = ch;
						push_byte(1'b1, ch, 3'd1, 1'b1);
						cur_col = cur_col + 6'd1;
					end else begin
						// cell already holds it: step past it, sending the address unless at end of row
						cur_col = cur_col + 6'd1;
						if (cur_col < COLUMNS)
							push_byte(1'b0, cell_address(cur_row, cur_col), 3'd1, 1'b1);
					end
				end
			end
		endcase
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: pulse %0d %s mismatch, expected %0d actual %0d",
				$time, checked, name, want, got);
			fails = fails + 1;
		end
	endtask

	// compare strobes, then take in newly accepted commands
	always @(posedge clk or negedge arst_n) begin
		lcd_pulse_t w;
		if (!arst_n) begin
			expected_pulses.delete();
			for (int i = 0; i < 2 * COLUMNS; i++)
				shadow[i] = 8'h00;
			cur_row = 2'd0;
			cur_col = 6'd0;
		end else begin
			if (strobe) begin
				if (expected_pulses.size() == 0) begin
					$display("%0t: unexpected pulse, expected none actual rs=%0d nib=%0h",
						$time, reg_select, nibble);
					fails = fails + 1;
				end else begin
					w = expected_pulses.pop_front();
					check_field("reg_select", w.rs, reg_select);
					check_field("nibble", w.nib, nibble);
					check_field("wait_before_ms", w.pre, wait_before_ms);
					check_field("wait_after_ms", w.after, wait_after_ms);
					check_field("last", w.fin, last);
				end
				checked = checked + 1;
			end
			if (start && !busy)
				predict_pulses(cmd_t'(command), row, column, character);
		end
		pending = expected_pulses.size();
	end

endmodule

// ----- test/tb.sv -----
// Testbench top: drives LCD writer commands, hosts the checker and reports the verdict.
`timescale 1ns / 1ps
module tb;
	import clsw_pkg::*;

	localparam int COLUMNS     = 16;
	localparam int RANDOM_CMDS = 260;
	localparam int CYCLE_LIMIT = 100000;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       start     = 1'b0;
	logic [1:0] command   = 2'd0;
	logic [1:0] row       = 2'd0;
	logic [5:0] column    = 6'd0;
	logic [7:0] character = 8'd0;
	logic       busy;
	logic       strobe;
	logic       reg_select;
	logic [3:0] nibble;
	logic [5:0] wait_before_ms;
	logic [2:0] wait_after_ms;
	logic       last;
	int         fails;
	int         pending;
	int         checked;
	int         cycles   = 0;
	int         issued   = 0;
	bit         idle_ok  = 1'b1;

	always #4 clk = ~clk;

	char_lcd_shadow_writer #(.COLUMNS(COLUMNS)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .row(row), .column(column), .character(character),
		.strobe(strobe), .reg_select(reg_select), .nibble(nibble),
		.wait_before_ms(wait_before_ms), .wait_after_ms(wait_after_ms), .last(last)
	);

	char_lcd_shadow_writer_checker #(.COLUMNS(COLUMNS)) u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .row(row), .column(column), .character(character),
		.strobe(strobe), .reg_select(reg_select), .nibble(nibble),
		.wait_before_ms(wait_before_ms), .wait_after_ms(wait_after_ms), .last(last),
		.fails(fails), .pending(pending), .checked(checked)
	);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// present one item, with an occasional gap first, and hold it until taken
	task automatic issue(input cmd_t c, input logic [1:0] r, input logic [5:0] col,
			input logic [7:0] ch);
		int gap;
		if (idle_ok && $urandom_range(0, 99) < 16) begin
			gap = $urandom_range(1, 6);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		command   <= c;
		row       <= r;
		column    <= col;
		character <= ch;
		do @(posedge clk); while (busy);
		issued++;
	endtask

	// small pool so that shadow hits are common
	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 3))
			0: return SPACE;
			1: return 8'h41;
			2: return 8'h42;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		int sel;
		int nwr;
		logic [1:0] r;
		logic [5:0] col;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: writes before init see zeroed cells
		issue(CMD_WRITE, 2'd0, 6'd0, 8'h00);
		issue(CMD_WRITE, 2'd0, 6'd0, 8'hFF);
		issue(CMD_CURSOR, 2'd0, 6'(COLUMNS - 1), 8'h00);
		issue(CMD_WRITE, 2'd0, 6'd0, 8'h00);
		issue(CMD_WRITE, 2'd0, 6'd0, 8'h5A);
		issue(CMD_INIT, 2'd3, 6'd63, 8'hFF);
		// skip at the end of the second row
		issue(CMD_CURSOR, 2'd1, 6'(COLUMNS - 1), 8'h00);
		issue(CMD_WRITE, 2'd0, 6'd0, SPACE);
		// cursor off the display, address taken from the second row's base
		issue(CMD_CURSOR, 2'd3, 6'd63, 8'h00);
		issue(CMD_WRITE, 2'd0, 6'd0, 8'h41);
		issue(CMD_CURSOR, 2'd2, 6'd0, 8'h00);
		issue(CMD_WRITE, 2'd0, 6'd0, 8'h41);
		// changed cell, unchanged cell, changed cell
		issue(CMD_CURSOR, 2'd0, 6'd0, 8'h00);
		issue(CMD_WRITE, 2'd0, 6'd0, 8'h41);
		issue(CMD_WRITE, 2'd0, 6'd0, SPACE);
		issue(CMD_WRITE, 2'd0, 6'd0, 8'h00);
		issue(CMD_CURSOR, 2'd1, 6'd0, 8'h00);
		issue(CMD_WRITE, 2'd0, 6'd0, 8'hFF);
		issue(CMD_CURSOR, 2'd1, 6'd0, 8'h00);
		issue(CMD_WRITE, 2'd0, 6'd0, 8'hFF);
		issue(CMD_CLEAR, 2'd0, 6'd0, 8'h00);
		issue(CMD_WRITE, 2'd0, 6'd0, SPACE);
		issue(CMD_CURSOR, 2'd0, 6'd40, 8'h00);
		issue(CMD_WRITE, 2'd0, 6'd0, 8'h7E);
		issue(CMD_INIT, 2'd0, 6'd0, 8'h00);

		// random: mostly cursor moves followed by runs of writes
		for (int k = 0; k < RANDOM_CMDS; ) begin
			idle_ok = !(k >= 90 && k < 150);
			sel = $urandom_range(0, 99);
			if (sel < 8) begin
				issue(CMD_INIT, 2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
					8'($urandom_range(0, 255)));
				k++;
			end else if (sel < 16) begin
				issue(CMD_CLEAR, 2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
					8'($urandom_range(0, 255)));
				k++;
			end else if (sel < 80) begin
				r   = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3))
					: 2'($urandom_range(0, 1));
				col = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
					: 6'($urandom_range(0, COLUMNS - 1));
				issue(CMD_CURSOR, r, col, 8'($urandom_range(0, 255)));
				k++;
				nwr = $urandom_range(1, 6);
				repeat (nwr) begin
					issue(CMD_WRITE, 2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
						pick_char());
					k++;
				end
			end else begin
				issue(cmd_t'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
					6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
				k++;
			end
		end
		start <= 1'b0;

		// drain, then keep watching for stray pulses
		do @(negedge clk); while (pending != 0 || busy);
		repeat (30) @(posedge clk);

		$display("Issued %0d commands (init, clear, cursor moves in and out of range,", issued);
		$display("shadow hits and misses, end-of-row skips); %0d pulses compared.", checked);
		if (fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- char_lcd_shadow_writer.f -----
rtl/core/clsw_pkg.sv
rtl/core/char_lcd_shadow_writer.sv
test/char_lcd_shadow_writer_checker.sv
test/tb.sv
